/* rtl/core/mcef_pkg.sv */
// ----------------------------------------------------------------------------
// mcef_pkg
// Shared types and constants for the exact-fraction move clipper.
// ----------------------------------------------------------------------------
package mcef_pkg;

    localparam int MAX_PLANES_DEFAULT = 64;
    localparam int QUEUE_DEPTH        = 4;
    localparam int OFFSET_W           = 6;
    localparam int FRAC_W             = 31;
    localparam int COORD_W            = 16;
    localparam int ADDR_W             = 5;
    localparam int DATA_W             = 32;

    localparam logic [2:0] REG_REL_X   = 3'd0;
    localparam logic [2:0] REG_REL_Y   = 3'd1;
    localparam logic [2:0] REG_REL_Z   = 3'd2;
    localparam logic [2:0] REG_MOVE_DX = 3'd3;
    localparam logic [2:0] REG_MOVE_DY = 3'd4;
    localparam logic [2:0] REG_MOVE_DZ = 3'd5;
    localparam logic [2:0] REG_CELL_ID = 3'd6;

    typedef struct packed {
        logic                cand;
        logic                last;
        logic                ovf;
        logic [OFFSET_W-1:0] offset;
        logic [FRAC_W-1:0]   num;
        logic [FRAC_W-1:0]   den;
    } entry_t;

endpackage

/* rtl/core/mcef_front.sv */
// ----------------------------------------------------------------------------
// mcef_front
// Accepts planes, forms the two dot products and classifies each plane.
// ----------------------------------------------------------------------------
module mcef_front #(
    parameter int MAX_PLANES_PER_CELL = mcef_pkg::MAX_PLANES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_plane_px,
    input  logic signed [15:0]   s_plane_py,
    input  logic signed [15:0]   s_plane_pz,
    input  logic signed [15:0]   s_normal_x,
    input  logic signed [15:0]   s_normal_y,
    input  logic signed [15:0]   s_normal_z,
    input  logic                 s_plane_present,
    input  logic                 s_last_plane,
    input  logic signed [15:0]   rel_x,
    input  logic signed [15:0]   rel_y,
    input  logic signed [15:0]   rel_z,
    input  logic signed [15:0]   move_dx,
    input  logic signed [15:0]   move_dy,
    input  logic signed [15:0]   move_dz,
    input  logic                 q_full,
    output logic                 push,
    output mcef_pkg::entry_t     push_entry
);

    localparam int CW = $clog2(MAX_PLANES_PER_CELL + 1);

    logic                            a_valid_reg, a_valid_next;
    logic [31:0]                     pn_x_reg, pn_y_reg, pn_z_reg;
    logic [31:0]                     pd_x_reg, pd_y_reg, pd_z_reg;
    logic                            taken_reg, last_reg, ovf_a_reg;
    logic [mcef_pkg::OFFSET_W-1:0]   off_reg;
    logic [CW-1:0]                   seen_reg, seen_next;
    logic                            ovf_reg, ovf_next;

    logic                            accept, full_cell, ovf_item, cand, need_push, advance;
    logic signed [16:0]              ex_x, ex_y, ex_z;
    logic signed [32:0]              mn_x, mn_y, mn_z;
    logic signed [31:0]              md_x, md_y, md_z;
    logic [31:0]                     num_sum, den_sum;

    assign accept    = s_valid && s_ready;
    assign full_cell = seen_reg >= CW'(MAX_PLANES_PER_CELL);
    assign ovf_item  = ovf_reg || (s_plane_present && full_cell);

    always_comb begin
        ex_x = $signed({s_plane_px[15], s_plane_px}) - $signed({rel_x[15], rel_x});
        ex_y = $signed({s_plane_py[15], s_plane_py}) - $signed({rel_y[15], rel_y});
        ex_z = $signed({s_plane_pz[15], s_plane_pz}) - $signed({rel_z[15], rel_z});
        mn_x = ex_x * s_normal_x;
        mn_y = ex_y * s_normal_y;
        mn_z = ex_z * s_normal_z;
        md_x = s_normal_x * move_dx;
        md_y = s_normal_y * move_dy;
        md_z = s_normal_z * move_dz;
    end

    always_comb begin
        num_sum   = pn_x_reg + pn_y_reg + pn_z_reg;
        den_sum   = pd_x_reg + pd_y_reg + pd_z_reg;
        cand      = taken_reg && (den_sum != 32'd0) && !den_sum[31] && !num_sum[31];
        need_push = a_valid_reg && (cand || last_reg);
        advance   = !need_push || !q_full;
        s_ready   = advance;
        push      = need_push && !q_full;
        push_entry.cand   = cand;
        push_entry.last   = last_reg;
        push_entry.ovf    = ovf_a_reg;
        push_entry.offset = off_reg;
        push_entry.num    = num_sum[30:0];
        push_entry.den    = den_sum[30:0];
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        seen_next    = seen_reg;
        ovf_next     = ovf_reg;
        if (advance) begin
            a_valid_next = 1'b0;
        end
        if (accept) begin
            a_valid_next = 1'b1;
            if (s_plane_present && !full_cell) begin
                seen_next = seen_reg + CW'(1);
            end
            ovf_next = ovf_item;
            if (s_last_plane) begin
                seen_next = '0;
                ovf_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            seen_reg    <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            seen_reg    <= seen_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pn_x_reg  <= mn_x[31:0];
            pn_y_reg  <= mn_y[31:0];
            pn_z_reg  <= mn_z[31:0];
            pd_x_reg  <= md_x;
            pd_y_reg  <= md_y;
            pd_z_reg  <= md_z;
            taken_reg <= s_plane_present && !full_cell;
            last_reg  <= s_last_plane;
            ovf_a_reg <= ovf_item;
            off_reg   <= mcef_pkg::OFFSET_W'(seen_reg);
        end
    end

endmodule

/* rtl/core/mcef_queue.sv */
// ----------------------------------------------------------------------------
// mcef_queue
// Short FIFO of classified planes between the front and the back.
// ----------------------------------------------------------------------------
module mcef_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mcef_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output mcef_pkg::entry_t head,
    output logic             empty
);

    localparam int DEPTH = mcef_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    mcef_pkg::entry_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full  = count_reg == (AW + 1)'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + (AW + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/mcef_back.sv */
// ----------------------------------------------------------------------------
// mcef_back
// Exact cross-product compare against the running best and result output.
// ----------------------------------------------------------------------------
module mcef_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  mcef_pkg::entry_t               head,
    output logic                           pop,
    input  logic [15:0]                    cell_id,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mcef_pkg::FRAC_W-1:0]    m_frac_num,
    output logic [mcef_pkg::FRAC_W-1:0]    m_frac_den,
    output logic                           m_hit_found,
    output logic [mcef_pkg::OFFSET_W-1:0]  m_hit_offset,
    output logic [15:0]                    m_hit_cell,
    output logic                           m_plane_overflow
);

    localparam int FW = mcef_pkg::FRAC_W;
    localparam int OW = mcef_pkg::OFFSET_W;

    typedef enum logic [1:0] {
        ST_MUL = 2'b01,
        ST_CMP = 2'b10
    } back_state_t;

    back_state_t       state_reg, state_next;
    mcef_pkg::entry_t  cur_reg;
    logic [2*FW-1:0]   prod_a_reg, prod_b_reg;
    logic [FW-1:0]     min_num_reg, min_num_next, min_den_reg, min_den_next;
    logic [OW-1:0]     best_off_reg, best_off_next;
    logic              any_hit_reg, any_hit_next;
    logic              out_valid_reg, out_valid_next;
    logic [FW-1:0]     out_num_reg, out_den_reg;
    logic              out_hit_reg, out_ovf_reg;
    logic [OW-1:0]     out_off_reg;
    logic [15:0]       out_cell_reg;

    logic              in_cmp, better, emit, finish;
    logic [FW-1:0]     upd_num, upd_den;
    logic [OW-1:0]     upd_off;
    logic              upd_hit;

    assign in_cmp = state_reg == ST_CMP;
    assign pop    = (state_reg == ST_MUL) && !q_empty;
    assign better = cur_reg.cand && (prod_a_reg < prod_b_reg);
    assign finish = in_cmp && (!cur_reg.last || !out_valid_reg || m_ready);
    assign emit   = finish && cur_reg.last;

    always_comb begin
        upd_num = better ? cur_reg.num : min_num_reg;
        upd_den = better ? cur_reg.den : min_den_reg;
        upd_off = better ? cur_reg.offset : best_off_reg;
        upd_hit = better || any_hit_reg;
    end

    always_comb begin
        state_next     = state_reg;
        min_num_next   = min_num_reg;
        min_den_next   = min_den_reg;
        best_off_next  = best_off_reg;
        any_hit_next   = any_hit_reg;
        out_valid_next = out_valid_reg && !m_ready;
        case (state_reg)
            ST_MUL: begin
                if (pop) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (finish) begin
                    state_next = ST_MUL;
                    if (cur_reg.last) begin
                        min_num_next   = FW'(1);
                        min_den_next   = FW'(1);
                        best_off_next  = '0;
                        any_hit_next   = 1'b0;
                        out_valid_next = 1'b1;
                    end else begin
                        min_num_next  = upd_num;
                        min_den_next  = upd_den;
                        best_off_next = upd_off;
                        any_hit_next  = upd_hit;
                    end
                end
            end
            default: begin
                state_next = ST_MUL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_MUL;
            min_num_reg   <= FW'(1);
            min_den_reg   <= FW'(1);
            best_off_reg  <= '0;
            any_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            min_num_reg   <= min_num_next;
            min_den_reg   <= min_den_next;
            best_off_reg  <= best_off_next;
            any_hit_reg   <= any_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg    <= head;
            prod_a_reg <= head.num * min_den_reg;
            prod_b_reg <= head.den * min_num_reg;
        end
        if (emit) begin
            out_num_reg  <= upd_num;
            out_den_reg  <= upd_den;
            out_hit_reg  <= upd_hit;
            out_off_reg  <= upd_hit ? upd_off : '0;
            out_cell_reg <= upd_hit ? cell_id : 16'd0;
            out_ovf_reg  <= cur_reg.ovf;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frac_num       = out_num_reg;
    assign m_frac_den       = out_den_reg;
    assign m_hit_found      = out_hit_reg;
    assign m_hit_offset     = out_off_reg;
    assign m_hit_cell       = out_cell_reg;
    assign m_plane_overflow = out_ovf_reg;

endmodule

/* rtl/core/move_clip_exact_fraction.sv */
// ----------------------------------------------------------------------------
// move_clip_exact_fraction
// Clips a move against the planes of one convex cell, keeping the smallest
// exit fraction with an exact cross-product compare.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Carries
//  s_*       in         s_valid/s_ready    one plane or end marker per transfer
//  m_*       out        m_valid/m_ready    one clip result per cell
//  APB       in         psel/penable       position, move and cell id registers
//
// The front takes one plane per cycle unless a full queue stalls it, registering
// the dot-product terms. The back pops a plane that can hit or an end-of-cell item
// in ST_MUL and pops no more until ST_CMP compares it; other planes drop early.
// A four-entry queue lets the front keep accepting while the back or m_ready stalls.
// Reset is synchronous on aresetn and needs no clearing pass.
// ----------------------------------------------------------------------------
module move_clip_exact_fraction #(
    parameter int MAX_PLANES_PER_CELL = mcef_pkg::MAX_PLANES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mcef_pkg::ADDR_W-1:0]    paddr,
    input  logic [mcef_pkg::DATA_W-1:0]    pwdata,
    output logic [mcef_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [15:0]             s_plane_px,
    input  logic signed [15:0]             s_plane_py,
    input  logic signed [15:0]             s_plane_pz,
    input  logic signed [15:0]             s_normal_x,
    input  logic signed [15:0]             s_normal_y,
    input  logic signed [15:0]             s_normal_z,
    input  logic                           s_plane_present,
    input  logic                           s_last_plane,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mcef_pkg::FRAC_W-1:0]    m_frac_num,
    output logic [mcef_pkg::FRAC_W-1:0]    m_frac_den,
    output logic                           m_hit_found,
    output logic [mcef_pkg::OFFSET_W-1:0]  m_hit_offset,
    output logic [15:0]                    m_hit_cell,
    output logic                           m_plane_overflow
);

    logic signed [15:0] rel_x_reg, rel_y_reg, rel_z_reg;
    logic signed [15:0] move_dx_reg, move_dy_reg, move_dz_reg;
    logic [15:0]        cell_id_reg;
    logic [2:0]         reg_index;
    logic               wr_en;

    logic               q_push, q_pop, q_full, q_empty;
    mcef_pkg::entry_t   q_in, q_head;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_x_reg   <= '0;
            rel_y_reg   <= '0;
            rel_z_reg   <= '0;
            move_dx_reg <= '0;
            move_dy_reg <= '0;
            move_dz_reg <= '0;
            cell_id_reg <= '0;
        end else if (wr_en) begin
            case (reg_index)
                mcef_pkg::REG_REL_X:   rel_x_reg   <= pwdata[15:0];
                mcef_pkg::REG_REL_Y:   rel_y_reg   <= pwdata[15:0];
                mcef_pkg::REG_REL_Z:   rel_z_reg   <= pwdata[15:0];
                mcef_pkg::REG_MOVE_DX: move_dx_reg <= pwdata[15:0];
                mcef_pkg::REG_MOVE_DY: move_dy_reg <= pwdata[15:0];
                mcef_pkg::REG_MOVE_DZ: move_dz_reg <= pwdata[15:0];
                mcef_pkg::REG_CELL_ID: cell_id_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            mcef_pkg::REG_REL_X:   prdata = {16'd0, rel_x_reg};
            mcef_pkg::REG_REL_Y:   prdata = {16'd0, rel_y_reg};
            mcef_pkg::REG_REL_Z:   prdata = {16'd0, rel_z_reg};
            mcef_pkg::REG_MOVE_DX: prdata = {16'd0, move_dx_reg};
            mcef_pkg::REG_MOVE_DY: prdata = {16'd0, move_dy_reg};
            mcef_pkg::REG_MOVE_DZ: prdata = {16'd0, move_dz_reg};
            mcef_pkg::REG_CELL_ID: prdata = {16'd0, cell_id_reg};
            default:               prdata = '0;
        endcase
    end

    mcef_front #(
        .MAX_PLANES_PER_CELL(MAX_PLANES_PER_CELL)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_plane_px      (s_plane_px),
        .s_plane_py      (s_plane_py),
        .s_plane_pz      (s_plane_pz),
        .s_normal_x      (s_normal_x),
        .s_normal_y      (s_normal_y),
        .s_normal_z      (s_normal_z),
        .s_plane_present (s_plane_present),
        .s_last_plane    (s_last_plane),
        .rel_x           (rel_x_reg),
        .rel_y           (rel_y_reg),
        .rel_z           (rel_z_reg),
        .move_dx         (move_dx_reg),
        .move_dy         (move_dy_reg),
        .move_dz         (move_dz_reg),
        .q_full          (q_full),
        .push            (q_push),
        .push_entry      (q_in)
    );

    mcef_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    mcef_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_empty          (q_empty),
        .head             (q_head),
        .pop              (q_pop),
        .cell_id          (cell_id_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frac_num       (m_frac_num),
        .m_frac_den       (m_frac_den),
        .m_hit_found      (m_hit_found),
        .m_hit_offset     (m_hit_offset),
        .m_hit_cell       (m_hit_cell),
        .m_plane_overflow (m_plane_overflow)
    );

endmodule

/* tb/move_clip_exact_fraction_test.sv */
// ----------------------------------------------------------------------------
// move_clip_exact_fraction_test
// Self-checking testbench for the exact-fraction move clipper. Cells of planes
// are streamed in under several register settings, and each clip result is
// predicted and compared with what the block reports.
// ----------------------------------------------------------------------------
module move_clip_exact_fraction_test;

    localparam int PLANE_CAP = 64;
    localparam int FW = mcef_pkg::FRAC_W;
    localparam int OW = mcef_pkg::OFFSET_W;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               present;
        logic               last;
    } plane_item_t;

    typedef struct {
        logic [FW-1:0]   num;
        logic [FW-1:0]   den;
        logic            hit;
        logic [OW-1:0]   offset;
        logic [15:0]     hit_cell;
        logic            ovf;
    } clip_result_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [mcef_pkg::ADDR_W-1:0]        paddr = '0;
    logic [mcef_pkg::DATA_W-1:0]        pwdata = '0;
    logic [mcef_pkg::DATA_W-1:0]        prdata;
    logic                               pready;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic signed [15:0]                 s_plane_px = '0;
    logic signed [15:0]                 s_plane_py = '0;
    logic signed [15:0]                 s_plane_pz = '0;
    logic signed [15:0]                 s_normal_x = '0;
    logic signed [15:0]                 s_normal_y = '0;
    logic signed [15:0]                 s_normal_z = '0;
    logic                               s_plane_present = 1'b0;
    logic                               s_last_plane = 1'b0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [FW-1:0]                      m_frac_num;
    logic [FW-1:0]                      m_frac_den;
    logic                               m_hit_found;
    logic [OW-1:0]                      m_hit_offset;
    logic [15:0]                        m_hit_cell;
    logic                               m_plane_overflow;

    move_clip_exact_fraction #(
        .MAX_PLANES_PER_CELL(PLANE_CAP)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_plane_px(s_plane_px),
        .s_plane_py(s_plane_py),
        .s_plane_pz(s_plane_pz),
        .s_normal_x(s_normal_x),
        .s_normal_y(s_normal_y),
        .s_normal_z(s_normal_z),
        .s_plane_present(s_plane_present),
        .s_last_plane(s_last_plane),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_frac_num(m_frac_num),
        .m_frac_den(m_frac_den),
        .m_hit_found(m_hit_found),
        .m_hit_offset(m_hit_offset),
        .m_hit_cell(m_hit_cell),
        .m_plane_overflow(m_plane_overflow)
    );

    always #4 aclk = ~aclk;

    logic signed [15:0] cfg_rel_x = '0;
    logic signed [15:0] cfg_rel_y = '0;
    logic signed [15:0] cfg_rel_z = '0;
    logic signed [15:0] cfg_move_dx = '0;
    logic signed [15:0] cfg_move_dy = '0;
    logic signed [15:0] cfg_move_dz = '0;
    logic [15:0]        cfg_cell_id = '0;

    logic [31:0]         lead_num = 32'd1;
    logic [31:0]         lead_den = 32'd1;
    logic [OW-1:0]       best_offset = '0;
    logic                any_hit = 1'b0;
    int                  planes_taken = 0;
    logic                spilled = 1'b0;

    plane_item_t  plane_feed[$];
    clip_result_t clip_results_due[$];
    plane_item_t  cur_plane;
    int           idle_odds = 0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           mismatches = 0;

    task automatic clip_plane(input plane_item_t it);
        int nx, ny, nz, ex, ey, ez;
        logic [31:0] den, num;
        logic [63:0] lhs, rhs;
        clip_result_t res;
        if (it.present) begin
            if (planes_taken >= PLANE_CAP) begin
                spilled = 1'b1;
            end else begin
                nx = int'(it.nx);
                ny = int'(it.ny);
                nz = int'(it.nz);
                ex = int'(it.px) - int'(cfg_rel_x);
                ey = int'(it.py) - int'(cfg_rel_y);
                ez = int'(it.pz) - int'(cfg_rel_z);
                den = nx * int'(cfg_move_dx) + ny * int'(cfg_move_dy) + nz * int'(cfg_move_dz);
                num = ex * nx + ey * ny + ez * nz;
                if (den != 32'd0 && !den[31] && !num[31]) begin
                    lhs = {32'd0, num} * {32'd0, lead_den};
                    rhs = {32'd0, den} * {32'd0, lead_num};
                    if (lhs < rhs) begin
                        lead_num = num;
                        lead_den = den;
                        best_offset = planes_taken[OW-1:0];
                        any_hit = 1'b1;
                    end
                end
                planes_taken++;
            end
        end
        if (it.last) begin
            res.num = lead_num[FW-1:0];
            res.den = lead_den[FW-1:0];
            res.hit = any_hit;
            res.offset = any_hit ? best_offset : '0;
            res.hit_cell = any_hit ? cfg_cell_id : '0;
            res.ovf = spilled;
            clip_results_due.push_back(res);
            lead_num = 32'd1;
            lead_den = 32'd1;
            best_offset = '0;
            any_hit = 1'b0;
            planes_taken = 0;
            spilled = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                clip_plane(cur_plane);
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (plane_feed.size() > 0) begin
                    cur_plane = plane_feed.pop_front();
                    s_plane_px <= cur_plane.px;
                    s_plane_py <= cur_plane.py;
                    s_plane_pz <= cur_plane.pz;
                    s_normal_x <= cur_plane.nx;
                    s_normal_y <= cur_plane.ny;
                    s_normal_z <= cur_plane.nz;
                    s_plane_present <= cur_plane.present;
                    s_last_plane <= cur_plane.last;
                    s_valid <= 1'b1;
                    if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
                        send_gap <= $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic bit field_ok(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        clip_result_t want;
        bit ok;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (clip_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual num %0h den %0h",
                             $time, m_frac_num, m_frac_den);
                    mismatches++;
                end else begin
                    want = clip_results_due.pop_front();
                    ok = 1'b1;
                    ok &= field_ok("frac_num", 32'(want.num), 32'(m_frac_num));
                    ok &= field_ok("frac_den", 32'(want.den), 32'(m_frac_den));
                    ok &= field_ok("hit_found", 32'(want.hit), 32'(m_hit_found));
                    ok &= field_ok("hit_offset", 32'(want.offset), 32'(m_hit_offset));
                    ok &= field_ok("hit_cell", 32'(want.hit_cell), 32'(m_hit_cell));
                    ok &= field_ok("plane_overflow", 32'(want.ovf), 32'(m_plane_overflow));
                    if (!ok) begin
                        mismatches++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
                    recv_gap <= $urandom_range(1, 8);
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom()), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            mcef_pkg::REG_REL_X:   cfg_rel_x = value;
            mcef_pkg::REG_REL_Y:   cfg_rel_y = value;
            mcef_pkg::REG_REL_Z:   cfg_rel_z = value;
            mcef_pkg::REG_MOVE_DX: cfg_move_dx = value;
            mcef_pkg::REG_MOVE_DY: cfg_move_dy = value;
            mcef_pkg::REG_MOVE_DZ: cfg_move_dz = value;
            mcef_pkg::REG_CELL_ID: cfg_cell_id = value;
            default: ;
        endcase
    endtask

    task automatic write_setting(input logic [15:0] rx, input logic [15:0] ry,
                                 input logic [15:0] rz, input logic [15:0] dx,
                                 input logic [15:0] dy, input logic [15:0] dz,
                                 input logic [15:0] cid);
        write_reg(mcef_pkg::REG_REL_X, rx);
        write_reg(mcef_pkg::REG_REL_Y, ry);
        write_reg(mcef_pkg::REG_REL_Z, rz);
        write_reg(mcef_pkg::REG_MOVE_DX, dx);
        write_reg(mcef_pkg::REG_MOVE_DY, dy);
        write_reg(mcef_pkg::REG_MOVE_DZ, dz);
        write_reg(mcef_pkg::REG_CELL_ID, cid);
    endtask

    task automatic wait_drained();
        while (plane_feed.size() != 0 || s_valid || clip_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
    endtask

    function automatic plane_item_t mk_plane(input int px, input int py, input int pz,
                                             input int nx, input int ny, input int nz,
                                             input logic present, input logic last);
        plane_item_t it;
        it.px = 16'(px);
        it.py = 16'(py);
        it.pz = 16'(pz);
        it.nx = 16'(nx);
        it.ny = 16'(ny);
        it.nz = 16'(nz);
        it.present = present;
        it.last = last;
        return it;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 100) - 50);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic plane_item_t random_plane(input bit near, input logic last);
        plane_item_t it;
        if (near) begin
            it.px = cfg_rel_x + 16'($urandom_range(0, 200) - 100);
            it.py = cfg_rel_y + 16'($urandom_range(0, 200) - 100);
            it.pz = cfg_rel_z + 16'($urandom_range(0, 200) - 100);
            it.nx = 16'($urandom_range(0, 16) - 8);
            it.ny = 16'($urandom_range(0, 16) - 8);
            it.nz = 16'($urandom_range(0, 16) - 8);
        end else begin
            it.px = 16'($urandom());
            it.py = 16'($urandom());
            it.pz = 16'($urandom());
            it.nx = 16'($urandom());
            it.ny = 16'($urandom());
            it.nz = 16'($urandom());
        end
        it.present = ($urandom_range(0, 9) != 0);
        it.last = last;
        return it;
    endfunction

    task automatic queue_cell(input int count);
        bit near;
        near = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++) begin
            plane_feed.push_back(random_plane(near, i == count - 1));
        end
    endtask

    initial begin
        int budget;
        int count;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers still hold their reset values, so the move is zero.
        idle_odds = 20;
        queue_cell(3);
        queue_cell(1);
        wait_drained();

        write_setting(16'd0, 16'd0, 16'd0, 16'd10, 16'd0, 16'd0, 16'h1234);
        plane_feed.push_back(mk_plane(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
        plane_feed.push_back(mk_plane(5, 0, 0, 1, 0, 0, 1'b1, 1'b0));
        plane_feed.push_back(mk_plane(2, 0, 0, 1, 0, 0, 1'b1, 1'b0));
        plane_feed.push_back(mk_plane(-1, -1, -1, -1, -1, -1, 1'b0, 1'b0));
        plane_feed.push_back(mk_plane(2, 0, 0, 1, 0, 0, 1'b1, 1'b0));
        plane_feed.push_back(mk_plane(7, 7, 7, 0, 0, 0, 1'b1, 1'b0));
        plane_feed.push_back(mk_plane(-5, 0, 0, 1, 0, 0, 1'b1, 1'b0));
        plane_feed.push_back(mk_plane(3, 0, 0, -1, 0, 0, 1'b1, 1'b1));
        plane_feed.push_back(mk_plane(10, 0, 0, 1, 0, 0, 1'b1, 1'b1));
        plane_feed.push_back(mk_plane(0, 0, 0, 1, 0, 0, 1'b1, 1'b0));
        plane_feed.push_back(mk_plane(0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
        wait_drained();

        write_setting(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff);
        plane_feed.push_back(mk_plane(32767, -32768, 32767, 32767, -32768, 32767, 1'b1, 1'b0));
        plane_feed.push_back(mk_plane(-32768, 32767, -32768, -32768, 32767, -32768,
                                      1'b1, 1'b0));
        plane_feed.push_back(mk_plane(32767, 32767, 32767, 1, -1, 1, 1'b1, 1'b0));
        plane_feed.push_back(mk_plane(-32768, -32768, -32768, 32767, 32767, 32767,
                                      1'b1, 1'b1));
        wait_drained();

        // Fractions shrink along the list, so the last plane within capacity wins
        // and the two beyond it raise the overflow flag.
        write_setting(16'd0, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0, 16'($urandom()));
        for (int i = 0; i < PLANE_CAP + 2; i++) begin
            plane_feed.push_back(mk_plane(PLANE_CAP + 2 - i, 0, 0, 1, 0, 0, 1'b1,
                                          i == PLANE_CAP + 1));
        end
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: idle_odds = 25;
                1: idle_odds = 40;
                2: idle_odds = 0;
                3: idle_odds = 15;
                4: idle_odds = 30;
                5: idle_odds = 50;
                default: idle_odds = 0;
            endcase
            if (phase == 3) begin
                write_setting(pick_value(), pick_value(), pick_value(), 16'd0, 16'd0, 16'd0,
                              16'd0);
            end else begin
                write_setting(pick_value(), pick_value(), pick_value(), pick_value(),
                              pick_value(), pick_value(), 16'($urandom()));
            end
            budget = 70;
            while (budget > 0) begin
                if ($urandom_range(0, 24) == 0) begin
                    count = $urandom_range(PLANE_CAP + 1, PLANE_CAP + 6);
                end else if ($urandom_range(0, 9) == 0) begin
                    count = 1;
                end else begin
                    count = $urandom_range(1, 8);
                end
                queue_cell(count);
                budget -= count;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
rtl/core/mcef_pkg.sv
rtl/core/mcef_front.sv
rtl/core/mcef_queue.sv
rtl/core/mcef_back.sv
rtl/core/move_clip_exact_fraction.sv
tb/move_clip_exact_fraction_test.sv
